@@ rtl/vdf_pkg.sv @@
// ----------------------------------------------------------------------------
// vdf_pkg
// shared widths, state codes and node entry layout for the distance fusion
// unit
// ----------------------------------------------------------------------------
package vdf_pkg;

  localparam int INDEX_W     = 14;
  localparam int DIST_W      = 16;
  localparam int WEIGHT_W    = 16;
  localparam int WSUM_W      = WEIGHT_W + 1;
  localparam int PROD_W      = 34;
  localparam int QUOT_W      = 16;
  localparam int DIV_CNT_W   = $clog2(QUOT_W);
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FUSION_MODE = 2'd0,
    CFG_INIT_DIST   = 2'd1,
    CFG_INIT_WEIGHT = 2'd2
  } cfg_reg_t;

  typedef enum logic [9:0] {
    ST_SWEEP = 10'b00_0000_0001,
    ST_IDLE  = 10'b00_0000_0010,
    ST_READ  = 10'b00_0000_0100,
    ST_MUL_A = 10'b00_0000_1000,
    ST_MUL_B = 10'b00_0001_0000,
    ST_SUM   = 10'b00_0010_0000,
    ST_ABS   = 10'b00_0100_0000,
    ST_DIV   = 10'b00_1000_0000,
    ST_WRITE = 10'b01_0000_0000,
    ST_DONE  = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic                written;
    logic [DIST_W-1:0]   distance;
    logic [WEIGHT_W-1:0] weight;
  } node_entry_t;

endpackage

@@ rtl/vdf_ram.sv @@
// ----------------------------------------------------------------------------
// vdf_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module vdf_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 16384,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/voxel_distance_fusion_unit.sv @@
// ----------------------------------------------------------------------------
// voxel_distance_fusion_unit
// per-node store of fused signed distance and weight, weighted running
// average or union-minimum fusion, one node read-modify-write per in-range
// fusion request
// weighted request: read, mul_a, mul_b, sum and abs states, then the
//   bit-serial divider (16 steps, one quotient bit a cycle), write and done
// union, zero weight sum: read, write, done; index out of range: done only
// clear request: clearing pass over the node ram, one ram entry cleared per cycle
// reset (rst, synchronous): configuration registers and out_valid to zero, then a
//   clearing pass over the node ram before the first request is taken
module voxel_distance_fusion_unit import vdf_pkg::*; #(
  parameter int NODE_COUNT = 16384
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration write port
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       clear_store,
  input  logic [INDEX_W-1:0]         node_index,
  input  logic signed [DIST_W-1:0]   new_distance,
  input  logic [WEIGHT_W-1:0]        new_weight,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [DIST_W-1:0]   fused_distance,
  output logic [WEIGHT_W-1:0]        fused_weight,
  output logic                       zero_weight_sum
);

  localparam int RAM_AW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int ENTRY_W   = $bits(node_entry_t);

  // configuration registers
  logic                      fusion_mode;
  logic [DIST_W-1:0]         initial_distance;
  logic [WEIGHT_W-1:0]       initial_weight;

  // control
  state_t                    state;
  logic [RAM_AW-1:0]         sweep_cnt;
  logic                      clear_pend;
  logic                      div_path;
  logic [DIV_CNT_W-1:0]      div_cnt;

  // request payload held for the whole read-modify-write
  logic [RAM_AW-1:0]         node_addr;
  logic [DIST_W-1:0]         new_dist;
  logic [WEIGHT_W-1:0]       new_wt;

  // working registers
  logic [DIST_W-1:0]         cur_dist;
  logic [WEIGHT_W-1:0]       cur_weight;
  logic [WSUM_W-1:0]         wsum;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  acc;
  logic                      num_neg;
  logic [WSUM_W-1:0]         rem;
  logic [QUOT_W-1:0]         dq;      // dividend low bits shift out, quotient bits shift in

  // result held until the output register is free
  logic [DIST_W-1:0]         res_dist;
  logic [WEIGHT_W-1:0]       res_weight;
  logic                      res_flag;

  // ram
  logic                      ram_wr_en;
  logic [RAM_AW-1:0]         ram_wr_addr;
  node_entry_t               ram_wr_entry;
  node_entry_t               rd_entry;
  logic [ENTRY_W-1:0]        ram_rd_data;

  logic                      in_accept;
  logic                      in_range;
  logic                      sweep_last;

  logic [DIST_W-1:0]         sel_dist;
  logic [WEIGHT_W-1:0]       sel_weight;
  logic [WSUM_W-1:0]         sel_wsum;
  logic [DIST_W:0]           sel_abs;
  logic [DIST_W:0]           new_abs;
  logic [DIST_W-1:0]         union_dist;

  logic signed [WSUM_W-1:0]  mul_a;
  logic signed [WSUM_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  mul_out;
  logic [PROD_W-1:0]         acc_mag;

  logic [WSUM_W:0]           trial;
  logic                      q_bit;
  logic [WSUM_W-1:0]         rem_next;

  logic [DIST_W-1:0]         wr_dist;
  logic [WEIGHT_W-1:0]       wr_weight;

  // handshake: one request in flight, the output register decouples the result side
  assign in_stall   = (state != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign in_range   = (32'(node_index) < NODE_COUNT);
  assign sweep_last = (sweep_cnt == RAM_AW'(NODE_COUNT - 1));

  // node lookup, unwritten nodes read as the configured initial values
  assign rd_entry   = node_entry_t'(ram_rd_data);
  assign sel_dist   = rd_entry.written ? rd_entry.distance : initial_distance;
  assign sel_weight = rd_entry.written ? rd_entry.weight : initial_weight;
  assign sel_wsum   = {1'b0, sel_weight} + {1'b0, new_wt};

  // union-minimum: nonzero new distance wins over zero or larger magnitude
  assign sel_abs = sel_dist[DIST_W-1] ? ((DIST_W+1)'(0) - {1'b1, sel_dist})
                                      : {1'b0, sel_dist};
  assign new_abs = new_dist[DIST_W-1] ? ((DIST_W+1)'(0) - {1'b1, new_dist})
                                      : {1'b0, new_dist};

  always_comb begin
    union_dist = sel_dist;
    if (new_dist != '0) begin
      if (sel_dist == '0 || sel_abs > new_abs) begin
        union_dist = new_dist;
      end
    end
  end

  // shared multiplier: stored term first, new term second
  assign mul_a   = (state == ST_MUL_A) ? {cur_dist[DIST_W-1], cur_dist}
                                       : {new_dist[DIST_W-1], new_dist};
  assign mul_b   = (state == ST_MUL_A) ? {1'b0, cur_weight} : {1'b0, new_wt};
  assign mul_out = mul_a * mul_b;

  // magnitude of the weighted sum, sign applied after the divide
  assign acc_mag = acc[PROD_W-1] ? PROD_W'(-acc) : PROD_W'(acc);

  // one restoring divide step per cycle
  assign trial    = {rem, dq[QUOT_W-1]};
  assign q_bit    = (trial >= {1'b0, wsum});
  assign rem_next = q_bit ? WSUM_W'(trial - {1'b0, wsum}) : trial[WSUM_W-1:0];

  // final node contents; the divide path truncates toward zero
  assign wr_dist   = div_path ? (num_neg ? DIST_W'(QUOT_W'(0) - dq) : DIST_W'(dq))
                              : res_dist;
  assign wr_weight = div_path ? wsum[WSUM_W-1:1] : res_weight;

  // ram write: clearing pass or write-back
  always_comb begin
    ram_wr_en             = 1'b0;
    ram_wr_addr           = node_addr;
    ram_wr_entry.written  = 1'b1;
    ram_wr_entry.distance = wr_dist;
    ram_wr_entry.weight   = wr_weight;
    if (state == ST_SWEEP) begin
      ram_wr_en    = 1'b1;
      ram_wr_addr  = sweep_cnt;
      ram_wr_entry = '0;
    end else if (state == ST_WRITE) begin
      ram_wr_en = 1'b1;
    end
  end

  vdf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_entry),
    .rd_en   (in_accept),
    .rd_addr (RAM_AW'(node_index)),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_SWEEP;
      sweep_cnt        <= '0;
      clear_pend       <= 1'b0;
      out_valid        <= 1'b0;
      fusion_mode      <= 1'b0;
      initial_distance <= '0;
      initial_weight   <= '0;
    end else begin
      // configuration writes, unknown indexes ignored
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_FUSION_MODE: fusion_mode      <= cfg_data[0];
          CFG_INIT_DIST:   initial_distance <= cfg_data[DIST_W-1:0];
          CFG_INIT_WEIGHT: initial_weight   <= cfg_data[WEIGHT_W-1:0];
          default: ;
        endcase
      end

      // the done state drives out_valid itself
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        // zero every entry, written bit included
        ST_SWEEP: begin
          if (sweep_last) begin
            sweep_cnt  <= '0;
            clear_pend <= 1'b0;
            state      <= clear_pend ? ST_DONE : ST_IDLE;
          end else begin
            sweep_cnt <= sweep_cnt + RAM_AW'(1);
          end
        end

        ST_IDLE: begin
          if (in_accept) begin
            node_addr <= RAM_AW'(node_index);
            new_dist  <= new_distance;
            new_wt    <= new_weight;
            div_path  <= 1'b0;
            res_flag  <= 1'b0;
            if (clear_store) begin
              res_dist   <= initial_distance;
              res_weight <= initial_weight;
              clear_pend <= 1'b1;
              state      <= ST_SWEEP;
            end else if (!in_range) begin
              res_dist   <= '0;
              res_weight <= '0;
              state      <= ST_DONE;
            end else begin
              state <= ST_READ;
            end
          end
        end

        // ram data is here; pick mode
        ST_READ: begin
          cur_dist   <= sel_dist;
          cur_weight <= sel_weight;
          wsum       <= sel_wsum;
          if (fusion_mode) begin
            res_dist   <= union_dist;
            res_weight <= sel_weight;
            state      <= ST_WRITE;
          end else if (sel_wsum == '0) begin
            res_dist   <= sel_dist;
            res_weight <= '0;
            res_flag   <= 1'b1;
            state      <= ST_WRITE;
          end else begin
            div_path <= 1'b1;
            state    <= ST_MUL_A;
          end
        end

        ST_MUL_A: begin
          prod  <= mul_out;
          state <= ST_MUL_B;
        end

        ST_MUL_B: begin
          acc   <= prod;
          prod  <= mul_out;
          state <= ST_SUM;
        end

        ST_SUM: begin
          acc   <= acc + prod;
          state <= ST_ABS;
        end

        // quotient fits 16 bits, so the upper dividend part starts below the divisor
        ST_ABS: begin
          num_neg <= acc[PROD_W-1];
          rem     <= acc_mag[QUOT_W +: WSUM_W];
          dq      <= acc_mag[QUOT_W-1:0];
          div_cnt <= '0;
          state   <= ST_DIV;
        end

        ST_DIV: begin
          rem     <= rem_next;
          dq      <= {dq[QUOT_W-2:0], q_bit};
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == '1) begin
            state <= ST_WRITE;
          end
        end

        // ram write-back happens this cycle
        ST_WRITE: begin
          res_dist   <= wr_dist;
          res_weight <= wr_weight;
          state      <= ST_DONE;
        end

        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            fused_distance  <= res_dist;
            fused_weight    <= res_weight;
            zero_weight_sum <= res_flag;
            out_valid       <= 1'b1;
            state           <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
